// File: rtl/sccc_pkg.sv
package sccc_pkg;

	localparam int SET_COUNT  = 256;
	localparam int WAY_COUNT  = 4;
	localparam int LINE_BYTES = 64;

	localparam int OFF_W  = $clog2(LINE_BYTES);
	localparam int SET_W  = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
	localparam int SET_SH = $clog2(SET_COUNT);
	localparam int WAY_W  = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;
	localparam int TAG_W  = 18;
	localparam int ST_W   = 3;

	// operations
	localparam logic [1:0] OP_READ    = 2'd0;
	localparam logic [1:0] OP_WRITE   = 2'd1;
	localparam logic [1:0] OP_SNOOP   = 2'd2;
	localparam logic [1:0] OP_RESOLVE = 2'd3;

	// line states
	localparam logic [2:0] ST_I  = 3'd0;
	localparam logic [2:0] ST_S  = 3'd1;
	localparam logic [2:0] ST_E  = 3'd2;
	localparam logic [2:0] ST_M  = 3'd3;
	localparam logic [2:0] ST_SC = 3'd4;
	localparam logic [2:0] ST_SM = 3'd5;

	// bus actions
	localparam logic [2:0] BA_NONE = 3'd0;
	localparam logic [2:0] BA_RD   = 3'd1;
	localparam logic [2:0] BA_RDX  = 3'd2;
	localparam logic [2:0] BA_UPGR = 3'd3;
	localparam logic [2:0] BA_UPD  = 3'd4;

	// pending kinds
	localparam logic [1:0] PK_NONE  = 2'd0;
	localparam logic [1:0] PK_RMISS = 2'd1;
	localparam logic [1:0] PK_WMISS = 2'd2;
	localparam logic [1:0] PK_WHIT  = 2'd3;

	// protocols
	localparam logic [1:0] PR_MSI    = 2'd0;
	localparam logic [1:0] PR_MESI   = 2'd1;
	localparam logic [1:0] PR_DRAGON = 2'd2;

	localparam logic [1:0] RP_NONE  = 2'd0;
	localparam logic [1:0] RP_FLUSH = 2'd1;
	localparam logic [1:0] RP_OPT   = 2'd2;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic update;
		logic clear;
	} sccc_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic result_ready;
		logic clear_last;
	} sccc_sts_t;

endpackage

// File: rtl/sccc_ram.sv
module sccc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: rtl/sccc_ctrl.sv
module sccc_ctrl import sccc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	output sccc_cmd_t cmd,
	input  sccc_sts_t sts
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_LOOK = 2'd1;
	localparam logic [1:0] S_OUT  = 2'd2;
	localparam logic [1:0] S_CLR  = 2'd3;

	logic [1:0] state_q;

	assign in_ready    = (state_q == S_IDLE);
	assign out_valid   = (state_q == S_OUT);
	assign cmd.capture = in_valid && in_ready;
	assign cmd.update  = (state_q == S_LOOK);
	assign cmd.clear   = (state_q == S_CLR);

	// clear all sets after reset, then read, write back, hand over the word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			unique case (state_q)
				S_CLR:  if (sts.clear_last) state_q <= S_IDLE;
				S_IDLE: if (in_valid) state_q <= S_LOOK;
				S_LOOK: state_q <= S_OUT;
				S_OUT:  if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_out_after_look: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update |=> out_valid) else $error("no result after update");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("accept while busy");
	a_ready_with_upd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update |-> sts.result_ready) else $error("status mismatch");
	a_no_accept_clr: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |-> !in_ready) else $error("accept while clearing");

endmodule

// File: rtl/sccc_dp.sv
module sccc_dp import sccc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  sccc_cmd_t   cmd,
	output sccc_sts_t   sts,
	input  logic [1:0]  protocol_mode,
	input  logic [1:0]  operation,
	input  logic [31:0] address,
	input  logic [2:0]  bus_action,
	input  logic        line_shared,
	output logic        hit,
	output logic [2:0]  bus_request,
	output logic        write_back,
	output logic [1:0]  snoop_reply,
	output logic        copies_signal,
	output logic [2:0]  line_state
);

	localparam int ENT_W = ST_W + TAG_W + 32;

	// captured item
	logic [1:0]       op_q;
	logic [SET_W-1:0] set_q;
	logic [TAG_W-1:0] tag_q;
	logic [2:0]       act_q;
	logic             cp_q;
	logic [1:0]       prot_q;
	logic [SET_W-1:0] set_in;
	logic [TAG_W-1:0] tag_in;
	logic [31:0]      blk;

	logic [31:0] acc_q;
	logic [1:0]  pend_q;
	logic        busy_q;
	logic [SET_W-1:0] clr_q;

	logic [ENT_W-1:0] rd [WAY_COUNT];
	logic [WAY_COUNT-1:0] we;
	logic [ENT_W-1:0] wdata;
	logic [SET_W-1:0] waddr;

	assign blk    = address >> OFF_W;
	assign set_in = SET_W'(blk);
	assign tag_in = TAG_W'(blk >> SET_SH);
	assign waddr  = cmd.clear ? clr_q : set_q;

	// one ram per way holding state, tag and stamp
	for (genvar w = 0; w < WAY_COUNT; w++) begin : g_way
		sccc_ram #(.WIDTH(ENT_W), .DEPTH(SET_COUNT)) u_ram (
			.clk(clk), .we(we[w]), .waddr(waddr), .wdata(wdata),
			.raddr(set_in), .rdata(rd[w])
		);
	end

	// lookup and transitions
	logic [ST_W-1:0]  sts_w [WAY_COUNT];
	logic             found, inv_found, wr;
	logic [WAY_W-1:0] fway, iway, lway, nway;
	logic [31:0]      minv, acc_n;
	logic [2:0]       st, nst;
	logic [1:0]       npend;
	logic             o_hit, o_wb, o_cs;
	logic [2:0]       o_req;
	logic [1:0]       o_rep;
	logic             touch, stwr;

	always_comb begin
		found = 1'b0; inv_found = 1'b0;
		fway = '0; iway = '0; lway = '0; minv = '1;
		for (int w = 0; w < WAY_COUNT; w++) begin
			sts_w[w] = rd[w][ENT_W-1 -: ST_W];
		end
		for (int w = WAY_COUNT-1; w >= 0; w--) begin
			if (sts_w[w] != ST_I && rd[w][32 +: TAG_W] == tag_q) begin
				found = 1'b1; fway = WAY_W'(w);
			end
			if (sts_w[w] == ST_I) begin
				inv_found = 1'b1; iway = WAY_W'(w);
			end
		end
		for (int w = 0; w < WAY_COUNT; w++) begin
			if (rd[w][31:0] <= minv) begin
				minv = rd[w][31:0]; lway = WAY_W'(w);
			end
		end
		wr = (op_q == OP_WRITE);
		acc_n = (acc_q == '1) ? acc_q : acc_q + 32'd1;
		nway = found ? fway : (inv_found ? iway : lway);
		st = sts_w[nway];
		nst = st; npend = pend_q;
		o_hit = 1'b0; o_wb = 1'b0; o_cs = 1'b0; o_req = BA_NONE; o_rep = RP_NONE;
		touch = 1'b0; stwr = 1'b0;
		case (op_q)
			OP_READ, OP_WRITE: begin
				touch = 1'b1; stwr = 1'b1; npend = PK_NONE;
				if (!found) begin
					o_wb = (st == ST_M) || (st == ST_SM);
					if (prot_q == PR_MESI) begin
						nst = wr ? ST_M : ST_E; o_req = wr ? BA_RDX : BA_RD;
						if (!wr) npend = PK_RMISS;
					end else if (prot_q == PR_DRAGON) begin
						nst = wr ? ST_SM : ST_SC; o_req = BA_RD;
						npend = wr ? PK_WMISS : PK_RMISS;
					end else begin
						nst = wr ? ST_M : ST_S; o_req = wr ? BA_RDX : BA_RD;
					end
				end else begin
					o_hit = 1'b1;
					if (wr) begin
						if (prot_q == PR_MESI) begin
							if (st == ST_S) begin nst = ST_M; o_req = BA_UPGR; end
							else if (st == ST_E) nst = ST_M;
						end else if (prot_q == PR_DRAGON) begin
							npend = PK_WHIT;
							if (st == ST_SC || st == ST_SM) o_req = BA_UPD;
						end else if (st == ST_S) begin
							nst = ST_M; o_req = BA_RDX;
						end
					end
				end
			end
			OP_SNOOP: begin
				stwr = found;
				if (prot_q == PR_MESI) begin
					if (st == ST_M || st == ST_E || st == ST_S) begin
						if (act_q == BA_RD) begin
							nst = ST_S; o_cs = 1'b1;
							o_rep = (st == ST_M) ? RP_FLUSH : RP_OPT;
						end else if (act_q == BA_RDX) begin
							nst = ST_I; o_rep = (st == ST_M) ? RP_FLUSH : RP_OPT;
						end else if (act_q == BA_UPGR && st == ST_S) nst = ST_I;
					end
				end else if (prot_q == PR_DRAGON) begin
					if (act_q == BA_RD) begin
						if (st == ST_E) begin nst = ST_SC; o_cs = 1'b1; end
						else if (st == ST_M) begin
							nst = ST_SM; o_rep = RP_FLUSH; o_cs = 1'b1;
						end else if (st == ST_SM) begin
							o_rep = RP_FLUSH; o_cs = 1'b1;
						end else if (st == ST_SC) o_cs = 1'b1;
					end else if (act_q == BA_UPD && st == ST_SM) nst = ST_SC;
				end else begin
					if (st == ST_M && act_q == BA_RD) begin
						nst = ST_S; o_rep = RP_FLUSH;
					end else if (st == ST_M && act_q == BA_RDX) begin
						nst = ST_I; o_rep = RP_FLUSH;
					end else if (st == ST_S && act_q == BA_RDX) nst = ST_I;
				end
				if (!found) o_rep = RP_NONE;
				if (!found) o_cs = 1'b0;
			end
			default: begin
				stwr = found; npend = PK_NONE;
				if (prot_q == PR_MESI) begin
					if (pend_q == PK_RMISS) nst = cp_q ? ST_S : ST_E;
				end else if (prot_q == PR_DRAGON) begin
					if (pend_q == PK_WMISS) begin
						nst = cp_q ? ST_SM : ST_M;
						if (cp_q && found) o_req = BA_UPD;
					end else if (pend_q == PK_RMISS) nst = cp_q ? ST_SC : ST_E;
					else if (pend_q == PK_WHIT) begin
						if (st == ST_E) nst = ST_M;
						else if (st == ST_SC || st == ST_SM) nst = cp_q ? ST_SM : ST_M;
					end
				end
			end
		endcase
	end

	// clearing writes invalid lines to every way, otherwise the chosen way
	assign wdata = cmd.clear ? '0 : {nst, tag_q, touch ? acc_n : rd[nway][31:0]};
	always_comb begin
		we = '0;
		if (cmd.clear) we = '1;
		else if (cmd.update && stwr) we[nway] = 1'b1;
	end
	assign sts.result_ready = busy_q;
	assign sts.clear_last   = (clr_q == SET_W'(SET_COUNT - 1));

	// capture item, then commit state and result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			pend_q <= PK_NONE;
			busy_q <= 1'b0;
			clr_q  <= '0;
		end else begin
			if (cmd.clear) clr_q <= clr_q + 1'b1;
			if (cmd.capture) busy_q <= 1'b1;
			if (cmd.update) begin
				busy_q <= 1'b0;
				pend_q <= npend;
				if (touch) acc_q <= acc_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q <= operation; set_q <= set_in; tag_q <= tag_in;
			act_q <= bus_action; cp_q <= line_shared;
			prot_q <= (protocol_mode == 2'd3) ? PR_MSI : protocol_mode;
		end
		if (cmd.update) begin
			hit <= o_hit; bus_request <= o_req; write_back <= o_wb;
			snoop_reply <= o_rep; copies_signal <= o_cs;
			line_state <= (stwr || touch) ? nst : ST_I;
		end
	end

	a_hit_proc: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update && o_hit |-> (op_q == OP_READ || op_q == OP_WRITE))
		else $error("hit on non-access");
	a_wb_miss: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update && o_wb |-> !found) else $error("write-back on hit");
	a_one_we: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.clear |-> $onehot0(we)) else $error("multiple way writes");

endmodule

// File: rtl/snooping_coherent_cache_controller.sv
// Snooping coherent cache tag and state store, SET_COUNT sets by WAY_COUNT
// ways. After reset a clearing pass over all SET_COUNT (256) sets marks every
// line invalid, and in_ready stays low until it ends. Each word (read, write,
// snoop or resolve) goes through the registered state/tag/stamp RAM read, then
// an update of the chosen way that registers the result, and the result is held
// until taken. A new word is accepted the cycle after the previous result has
// been taken, so words never overlap. protocol_mode selects MSI, MESI or
// Dragon (3 acts as MSI); the user must write it only while idle, and the
// block itself does not enforce this.
module snooping_coherent_cache_controller import sccc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  operation,
	input  logic [31:0] address,
	input  logic [2:0]  bus_action,
	input  logic        line_shared,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        hit,
	output logic [2:0]  bus_request,
	output logic        write_back,
	output logic [1:0]  snoop_reply,
	output logic        copies_signal,
	output logic [2:0]  line_state
);

	logic [1:0] mode_q;
	sccc_cmd_t  cmd;
	sccc_sts_t  sts;

	// protocol register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) mode_q <= PR_MSI;
		else if (cfg_we) mode_q <= cfg_wdata;
	end

	sccc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .cmd(cmd), .sts(sts)
	);

	sccc_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .protocol_mode(mode_q),
		.operation(operation), .address(address), .bus_action(bus_action),
		.line_shared(line_shared), .hit(hit), .bus_request(bus_request),
		.write_back(write_back), .snoop_reply(snoop_reply),
		.copies_signal(copies_signal), .line_state(line_state)
	);

endmodule
